// ===== design/adaline_lms_trainer_assert.svh =====
// assertion macros shared by the trainer rtl
`ifndef ADALINE_LMS_TRAINER_ASSERT_SVH
`define ADALINE_LMS_TRAINER_ASSERT_SVH

// same-cycle implication, disabled during reset
`define ADL_ASSERT_SAME(label, ck, rs, ante, cons, msg) \
  label: assert property (@(posedge ck) disable iff (rs) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, disabled during reset
`define ADL_ASSERT_NEXT(label, ck, rs, ante, cons, msg) \
  label: assert property (@(posedge ck) disable iff (rs) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== design/adl_pkg.sv =====
package adl_pkg;

  // neuron size and field counts
  localparam int WEIGHT_COUNT = 5;
  localparam int NUM_X_FIELDS = 5;

  // fixed point format, signed q3.20
  localparam int DATA_W = 24;
  localparam int FRAC   = 20;

  // configuration register widths
  localparam int ETA_W      = 23;
  localparam int TOL_W      = 23;
  localparam int EPOCH_W    = 8;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 23;

  // datapath widths
  localparam int PROD_W     = 2 * DATA_W;
  localparam int ACC_W      = PROD_W + $clog2(WEIGHT_COUNT);
  localparam int SAT_W      = ACC_W;
  localparam int ETA_PROD_W = 2 * DATA_W;
  localparam int STEP_W     = ETA_PROD_W - FRAC;
  localparam int DPROD_W    = STEP_W + DATA_W;
  localparam int DELTA_W    = DPROD_W - FRAC;
  localparam int SUM_W      = 32;
  localparam int MAC_CNT_W  = $clog2(WEIGHT_COUNT + 1);

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_LEARNING_RATE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ERROR_TOL     = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_EPOCHS    = 2'd2;

  // register reset values
  localparam logic [ETA_W-1:0]   ETA_RESET    = 23'd1048576;
  localparam logic [TOL_W-1:0]   TOL_RESET    = 23'd105;
  localparam logic [EPOCH_W-1:0] EPOCHS_RESET = 8'd20;

  // request modes
  localparam logic MODE_TRAIN = 1'b0;
  localparam logic MODE_LOAD  = 1'b1;

  localparam logic signed [DATA_W-1:0] Q_MAX = {1'b0, {(DATA_W-1){1'b1}}};
  localparam logic signed [DATA_W-1:0] Q_MIN = {1'b1, {(DATA_W-1){1'b0}}};

  typedef logic signed [DATA_W-1:0] q_t;

  typedef struct packed {
    logic mode;
    q_t   x_in_0;
    q_t   x_in_1;
    q_t   x_in_2;
    q_t   x_in_3;
    q_t   x_in_4;
    q_t   target;
    logic end_of_epoch;
  } in_payload_t;

  typedef struct packed {
    q_t   net_output;
    q_t   error_value;
    logic epoch_done;
    logic stop_training;
  } out_payload_t;

  // sequencer strobes to every cell
  typedef struct packed {
    logic capture;
    logic load;
    logic mul;
    logic apply;
  } cell_ctrl_t;

  // sequencer strobes to the epoch tracker
  typedef struct packed {
    logic clear;
    logic accumulate;
    logic close;
  } epoch_ctrl_t;

  // clamp a wide signed value into q3.20
  function automatic q_t sat_q(input logic signed [SAT_W-1:0] v);
    q_t r;
    if (v > SAT_W'(Q_MAX)) begin
      r = Q_MAX;
    end else if (v < SAT_W'(Q_MIN)) begin
      r = Q_MIN;
    end else begin
      r = v[DATA_W-1:0];
    end
    return r;
  endfunction

endpackage

// ===== design/adl_in_if.sv =====
interface adl_in_if;
  logic                 valid;
  logic                 ready;
  adl_pkg::in_payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

// ===== design/adl_out_if.sv =====
interface adl_out_if;
  logic                  valid;
  logic                  ready;
  adl_pkg::out_payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

// ===== design/adl_cell.sv =====
module adl_cell (
  input  logic                                clk,
  input  logic                                rst,
  input  adl_pkg::cell_ctrl_t                 ctrl,
  input  adl_pkg::q_t                         x_new,
  input  logic signed [adl_pkg::STEP_W-1:0]   step,
  input  logic signed [adl_pkg::ACC_W-1:0]    sum_in,
  output logic signed [adl_pkg::ACC_W-1:0]    sum_out
);

  adl_pkg::q_t                          w;
  adl_pkg::q_t                          x;
  adl_pkg::q_t                          w_next;
  logic signed [adl_pkg::PROD_W-1:0]    prod;
  logic signed [adl_pkg::DPROD_W-1:0]   dprod;
  logic signed [adl_pkg::DELTA_W-1:0]   delta;

  // weight held in this cell
  always_ff @(posedge clk) begin
    if (rst) begin
      w <= '0;
    end else if (ctrl.load) begin
      w <= x_new;
    end else if (ctrl.apply) begin
      w <= w_next;
    end
  end

  // pattern element captured at request
  always_ff @(posedge clk) begin
    if (ctrl.capture) begin
      x <= x_new;
    end
  end

  // product, then add into the partial sum passed down the row
  always_ff @(posedge clk) begin
    prod    <= adl_pkg::PROD_W'(w) * adl_pkg::PROD_W'(x);
    sum_out <= sum_in + adl_pkg::ACC_W'(prod);
  end

  // update product step * x
  always_ff @(posedge clk) begin
    if (ctrl.mul) begin
      dprod <= adl_pkg::DPROD_W'(step) * adl_pkg::DPROD_W'(x);
    end
  end

  // floor shift and saturating weight update
  always_comb begin
    delta  = adl_pkg::DELTA_W'(dprod >>> adl_pkg::FRAC);
    w_next = adl_pkg::sat_q(adl_pkg::SAT_W'(w) + adl_pkg::SAT_W'(delta));
  end

endmodule

// ===== design/adl_epoch.sv =====
module adl_epoch (
  input  logic                               clk,
  input  logic                               rst,
  input  adl_pkg::epoch_ctrl_t               ctrl,
  input  adl_pkg::q_t                        err,
  input  logic [adl_pkg::TOL_W-1:0]          tol,
  input  logic [adl_pkg::EPOCH_W-1:0]        max_epochs,
  output logic                               stop
);

  logic signed [adl_pkg::SUM_W-1:0] sum;
  logic signed [adl_pkg::SUM_W:0]   sum_ext;
  logic signed [adl_pkg::SUM_W-1:0] sum_next;
  logic [adl_pkg::SUM_W-1:0]        mag;
  logic [adl_pkg::EPOCH_W-1:0]      count;
  logic [adl_pkg::EPOCH_W-1:0]      count_next;

  // saturating error sum
  always_comb begin
    sum_ext = (adl_pkg::SUM_W + 1)'(sum) + (adl_pkg::SUM_W + 1)'(err);
    if (sum_ext[adl_pkg::SUM_W] != sum_ext[adl_pkg::SUM_W-1]) begin
      sum_next = {sum_ext[adl_pkg::SUM_W], {(adl_pkg::SUM_W-1){~sum_ext[adl_pkg::SUM_W]}}};
    end else begin
      sum_next = sum_ext[adl_pkg::SUM_W-1:0];
    end
  end

  // magnitude and saturating epoch count
  always_comb begin
    mag        = sum[adl_pkg::SUM_W-1] ? -sum : sum;
    count_next = (count == '1) ? count : count + 1'b1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sum   <= '0;
      count <= '0;
      stop  <= 1'b0;
    end else if (ctrl.clear) begin
      sum   <= '0;
      count <= '0;
    end else if (ctrl.accumulate) begin
      sum <= sum_next;
    end else if (ctrl.close) begin
      count <= count_next;
      stop  <= (mag <= adl_pkg::SUM_W'(tol)) || (count_next >= max_epochs);
      sum   <= '0;
    end
  end

endmodule

// ===== design/adaline_lms_trainer.sv =====
// adaline lms trainer: five-input linear neuron trained by widrow-hoff lms in q3.20
//
// train_in carries one request: mode, x_in_0..x_in_4, target, end_of_epoch.
// mode load writes the x fields into the weights, clears the epoch sum and
// count, and answers with an all-zero result.
// mode train applies the update to all weights, then answers with net_output
// and error_value (from before the weight update), epoch_done and stop_training.
// train_out gives one result per request, in order, valid/ready handshake.
// a train request steps through the mac, net, err, eta, step, mul, apply and
// done states; the next request is taken only once the block is back in idle.
// the steps are the product/sum wave through the row of weight cells, the
// shared learning-rate multiply and the per-cell update multiply and saturate.
// the cfg port writes learning_rate, error_tolerance, max_epochs at any edge
// with cfg_wr_en high; write it only while the block is idle.
// rst (synchronous) clears weights, epoch sum and count, and restores the
// register defaults (rate 1.0, tolerance 105, 20 epochs).
// when train_out stalls the result is held; a following request is still
// accepted and runs until its result waits for the output register to free.
module adaline_lms_trainer (
  input  logic                               clk,
  input  logic                               rst,
  adl_in_if.sink                             train_in,
  adl_out_if.source                          train_out,
  input  logic                               cfg_wr_en,
  input  logic [adl_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [adl_pkg::CFG_DATA_W-1:0]     cfg_data
);

`include "adaline_lms_trainer_assert.svh"

  typedef enum logic [3:0] {
    S_IDLE,
    S_MAC,
    S_NET,
    S_ERR,
    S_ETA,
    S_STEP,
    S_MUL,
    S_APPLY,
    S_DONE
  } state_t;

  state_t                                 state;
  logic [adl_pkg::MAC_CNT_W-1:0]          mac_cnt;
  logic [adl_pkg::ETA_W-1:0]              learning_rate;
  logic [adl_pkg::TOL_W-1:0]              error_tolerance;
  logic [adl_pkg::EPOCH_W-1:0]            max_epochs;
  adl_pkg::q_t                            target_r;
  logic                                   eoe_r;
  logic                                   load_r;
  adl_pkg::q_t                            net_r;
  adl_pkg::q_t                            err_r;
  logic signed [adl_pkg::ETA_PROD_W-1:0]  eta_prod;
  logic signed [adl_pkg::STEP_W-1:0]      step_r;
  logic                                   out_valid;
  adl_pkg::out_payload_t                  out_data;
  logic                                   accept;
  logic                                   out_free;
  logic signed [adl_pkg::DATA_W-1:0]      eta_s;
  adl_pkg::cell_ctrl_t                    cell_ctrl;
  adl_pkg::epoch_ctrl_t                   epoch_ctrl;
  logic                                   epoch_stop;
  adl_pkg::q_t                            x_fields [adl_pkg::NUM_X_FIELDS];
  logic signed [adl_pkg::ACC_W-1:0]       sums [adl_pkg::WEIGHT_COUNT+1];

  assign train_in.ready  = (state == S_IDLE);
  assign accept          = train_in.valid && train_in.ready;
  assign out_free        = !out_valid || train_out.ready;
  assign train_out.valid = out_valid;
  assign train_out.payload = out_data;
  assign eta_s           = $signed({1'b0, learning_rate});

  assign x_fields[0] = train_in.payload.x_in_0;
  assign x_fields[1] = train_in.payload.x_in_1;
  assign x_fields[2] = train_in.payload.x_in_2;
  assign x_fields[3] = train_in.payload.x_in_3;
  assign x_fields[4] = train_in.payload.x_in_4;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      learning_rate   <= adl_pkg::ETA_RESET;
      error_tolerance <= adl_pkg::TOL_RESET;
      max_epochs      <= adl_pkg::EPOCHS_RESET;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        adl_pkg::REG_LEARNING_RATE: learning_rate <= cfg_data[adl_pkg::ETA_W-1:0];
        adl_pkg::REG_ERROR_TOL:     error_tolerance <= cfg_data[adl_pkg::TOL_W-1:0];
        adl_pkg::REG_MAX_EPOCHS:    max_epochs <= cfg_data[adl_pkg::EPOCH_W-1:0];
        default: ;
      endcase
    end
  end

  // strobes to the cells and the epoch tracker
  always_comb begin
    cell_ctrl.capture = accept && (train_in.payload.mode == adl_pkg::MODE_TRAIN);
    cell_ctrl.load    = accept && (train_in.payload.mode == adl_pkg::MODE_LOAD);
    cell_ctrl.mul     = (state == S_MUL);
    cell_ctrl.apply   = (state == S_APPLY);
    epoch_ctrl.clear      = cell_ctrl.load;
    epoch_ctrl.accumulate = (state == S_ETA);
    epoch_ctrl.close      = (state == S_STEP) && eoe_r;
  end

  // row of weight cells, partial sum handed down the row
  assign sums[0] = '0;

  for (genvar i = 0; i < adl_pkg::WEIGHT_COUNT; i++) begin : g_cell
    adl_pkg::q_t x_cell;
    if (i < adl_pkg::NUM_X_FIELDS) begin : g_field
      assign x_cell = x_fields[i];
    end else begin : g_zero
      assign x_cell = '0;
    end
    adl_cell u_cell (
      .clk     (clk),
      .rst     (rst),
      .ctrl    (cell_ctrl),
      .x_new   (x_cell),
      .step    (step_r),
      .sum_in  (sums[i]),
      .sum_out (sums[i+1])
    );
  end

  adl_epoch u_epoch (
    .clk        (clk),
    .rst        (rst),
    .ctrl       (epoch_ctrl),
    .err        (err_r),
    .tol        (error_tolerance),
    .max_epochs (max_epochs),
    .stop       (epoch_stop)
  );

  // sequencer and result register
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      mac_cnt   <= '0;
      out_valid <= 1'b0;
      load_r    <= 1'b0;
      eoe_r     <= 1'b0;
    end else begin
      if (out_valid && train_out.ready && (state != S_DONE)) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (accept) begin
            target_r <= train_in.payload.target;
            eoe_r    <= train_in.payload.end_of_epoch;
            mac_cnt  <= '0;
            if (train_in.payload.mode == adl_pkg::MODE_LOAD) begin
              load_r <= 1'b1;
              state  <= S_DONE;
            end else begin
              load_r <= 1'b0;
              state  <= S_MAC;
            end
          end
        end
        S_MAC: begin
          // wait for the sum wave to reach the last cell
          if (mac_cnt == adl_pkg::MAC_CNT_W'(adl_pkg::WEIGHT_COUNT)) begin
            state <= S_NET;
          end else begin
            mac_cnt <= mac_cnt + 1'b1;
          end
        end
        S_NET: begin
          net_r <= adl_pkg::sat_q(sums[adl_pkg::WEIGHT_COUNT] >>> adl_pkg::FRAC);
          state <= S_ERR;
        end
        S_ERR: begin
          err_r <= adl_pkg::sat_q(adl_pkg::SAT_W'(target_r) - adl_pkg::SAT_W'(net_r));
          state <= S_ETA;
        end
        S_ETA: begin
          eta_prod <= adl_pkg::ETA_PROD_W'(eta_s) * adl_pkg::ETA_PROD_W'(err_r);
          state    <= S_STEP;
        end
        S_STEP: begin
          step_r <= adl_pkg::STEP_W'(eta_prod >>> adl_pkg::FRAC);
          state  <= S_MUL;
        end
        S_MUL: begin
          state <= S_APPLY;
        end
        S_APPLY: begin
          state <= S_DONE;
        end
        S_DONE: begin
          if (out_free) begin
            out_valid <= 1'b1;
            if (load_r) begin
              out_data <= '0;
            end else begin
              out_data.net_output    <= net_r;
              out_data.error_value   <= err_r;
              out_data.epoch_done    <= eoe_r;
              out_data.stop_training <= eoe_r && epoch_stop;
            end
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // checks on sequencing
  `ADL_ASSERT_NEXT(a_busy_after_accept, clk, rst, accept, !train_in.ready, "ready high after accept")
  `ADL_ASSERT_NEXT(a_load_direct, clk, rst, cell_ctrl.load, state == S_DONE, "load request did not go to result")
  `ADL_ASSERT_SAME(a_result_from_done, clk, rst, $rose(out_valid), $past(state == S_DONE), "result valid outside done")

endmodule

// ===== sim/adaline_lms_trainer_test.sv =====
`timescale 1ns / 1ps

// expected results of the trainer, kept from the accepted requests
class lms_scoreboard;
  localparam longint SUM_MAX = 64'sd2147483647;
  localparam longint SUM_MIN = -64'sd2147483648;

  adl_pkg::q_t                   weights [adl_pkg::WEIGHT_COUNT];
  longint                        error_sum;
  int unsigned                   epoch_count;
  logic [adl_pkg::ETA_W-1:0]     rate;
  logic [adl_pkg::TOL_W-1:0]     tolerance;
  logic [adl_pkg::EPOCH_W-1:0]   epoch_limit;
  adl_pkg::out_payload_t         expected_results [$];
  int                            mismatches;
  int                            checked;
  int                            loads;
  int                            trains;
  int                            epoch_ends;
  int                            stops;

  function new();
    foreach (weights[i]) weights[i] = '0;
    error_sum   = 0;
    epoch_count = 0;
    rate        = adl_pkg::ETA_RESET;
    tolerance   = adl_pkg::TOL_RESET;
    epoch_limit = adl_pkg::EPOCHS_RESET;
    mismatches  = 0;
    checked     = 0;
    loads       = 0;
    trains      = 0;
    epoch_ends  = 0;
    stops       = 0;
  endfunction

  function void write_register(logic [adl_pkg::CFG_IDX_W-1:0] index,
                               logic [adl_pkg::CFG_DATA_W-1:0] data);
    case (index)
      adl_pkg::REG_LEARNING_RATE: rate = data[adl_pkg::ETA_W-1:0];
      adl_pkg::REG_ERROR_TOL:     tolerance = data[adl_pkg::TOL_W-1:0];
      adl_pkg::REG_MAX_EPOCHS:    epoch_limit = data[adl_pkg::EPOCH_W-1:0];
      default: ;
    endcase
  endfunction

  function adl_pkg::q_t clamp_q(longint v);
    if (v > longint'(adl_pkg::Q_MAX)) return adl_pkg::Q_MAX;
    if (v < longint'(adl_pkg::Q_MIN)) return adl_pkg::Q_MIN;
    return adl_pkg::q_t'(v);
  endfunction

  // lms step for one accepted request
  function void note_request(adl_pkg::in_payload_t req);
    adl_pkg::q_t           x [adl_pkg::WEIGHT_COUNT];
    adl_pkg::q_t           net;
    adl_pkg::q_t           err;
    longint                acc;
    longint                step;
    longint                mag;
    adl_pkg::out_payload_t res;
    x[0] = req.x_in_0;
    x[1] = req.x_in_1;
    x[2] = req.x_in_2;
    x[3] = req.x_in_3;
    x[4] = req.x_in_4;
    res = '0;
    if (req.mode == adl_pkg::MODE_LOAD) begin
      // load weights and restart the epoch bookkeeping
      foreach (weights[i]) weights[i] = x[i];
      error_sum   = 0;
      epoch_count = 0;
      loads++;
    end else begin
      trains++;
      acc = 0;
      foreach (weights[i]) acc += longint'(weights[i]) * longint'(x[i]);
      net  = clamp_q(acc >>> adl_pkg::FRAC);
      err  = clamp_q(longint'(req.target) - longint'(net));
      step = (longint'(rate) * longint'(err)) >>> adl_pkg::FRAC;
      // update every weight with floor rounding and saturation
      foreach (weights[i])
        weights[i] = clamp_q(longint'(weights[i]) +
                             ((step * longint'(x[i])) >>> adl_pkg::FRAC));
      error_sum += longint'(err);
      if (error_sum > SUM_MAX) error_sum = SUM_MAX;
      if (error_sum < SUM_MIN) error_sum = SUM_MIN;
      res.net_output  = net;
      res.error_value = err;
      // epoch close: count, test, clear
      if (req.end_of_epoch) begin
        res.epoch_done = 1'b1;
        epoch_ends++;
        if (epoch_count < 255) epoch_count++;
        mag = (error_sum < 0) ? -error_sum : error_sum;
        res.stop_training = (mag <= longint'(tolerance)) || (epoch_count >= epoch_limit);
        if (res.stop_training) stops++;
        error_sum = 0;
      end
    end
    expected_results.push_back(res);
  endfunction

  task report(string field, longint got, longint want);
    mismatches++;
    $display("mismatch on result %0d: %s is %0d, expected %0d", checked, field, got, want);
  endtask

  task check_result(adl_pkg::out_payload_t got);
    adl_pkg::out_payload_t want;
    adl_pkg::q_t           got_net;
    adl_pkg::q_t           got_err;
    adl_pkg::q_t           want_net;
    adl_pkg::q_t           want_err;
    got_net = got.net_output;
    got_err = got.error_value;
    if (expected_results.size() == 0) begin
      report("net_output of unrequested result", got_net, 0);
      return;
    end
    want     = expected_results.pop_front();
    want_net = want.net_output;
    want_err = want.error_value;
    checked++;
    if (got_net != want_net) report("net_output", got_net, want_net);
    if (got_err != want_err) report("error_value", got_err, want_err);
    if (got.epoch_done != want.epoch_done)
      report("epoch_done", got.epoch_done, want.epoch_done);
    if (got.stop_training != want.stop_training)
      report("stop_training", got.stop_training, want.stop_training);
  endtask
endclass

module adaline_lms_trainer_test;
  localparam int WATCHDOG_LIMIT = 4000;
  localparam int SETTLE_CYCLES  = 16;

  logic                           clk = 1'b0;
  logic                           rst = 1'b1;
  logic                           cfg_wr_en;
  logic [adl_pkg::CFG_IDX_W-1:0]  cfg_index;
  logic [adl_pkg::CFG_DATA_W-1:0] cfg_data;

  adl_in_if  train_in_bus ();
  adl_out_if train_out_bus ();

  lms_scoreboard sb = new();

  int send_idle_pct    = 0;
  int recv_stall_pct   = 0;
  int items_sent       = 0;
  int settings_written = 0;
  int quiet_cycles     = 0;

  adaline_lms_trainer dut (
    .clk       (clk),
    .rst       (rst),
    .train_in  (train_in_bus),
    .train_out (train_out_bus),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // result side backpressure
  always @(negedge clk) begin
    train_out_bus.ready <= ($urandom_range(0, 99) >= recv_stall_pct);
  end

  // monitor both channels and the register port, plus the watchdog
  always @(posedge clk) begin
    if (!rst) begin
      if (train_out_bus.valid && train_out_bus.ready) sb.check_result(train_out_bus.payload);
      if (train_in_bus.valid && train_in_bus.ready) sb.note_request(train_in_bus.payload);
      if (cfg_wr_en) sb.write_register(cfg_index, cfg_data);
      if ((train_out_bus.valid && train_out_bus.ready) ||
          (train_in_bus.valid && train_in_bus.ready)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
      end
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("timeout: no handshake for %0d cycles", WATCHDOG_LIMIT);
        $display("FAIL adaline_lms_trainer");
        $finish;
      end
    end
  end

  function automatic adl_pkg::in_payload_t make_req(logic mode, adl_pkg::q_t x0,
                                                    adl_pkg::q_t x1, adl_pkg::q_t x2,
                                                    adl_pkg::q_t x3, adl_pkg::q_t x4,
                                                    adl_pkg::q_t tgt, logic eoe);
    adl_pkg::in_payload_t r;
    r.mode         = mode;
    r.x_in_0       = x0;
    r.x_in_1       = x1;
    r.x_in_2       = x2;
    r.x_in_3       = x3;
    r.x_in_4       = x4;
    r.target       = tgt;
    r.end_of_epoch = eoe;
    return r;
  endfunction

  function automatic adl_pkg::q_t rand_q();
    return adl_pkg::q_t'($urandom);
  endfunction

  // signed value in [-2^b, 2^b - 1]
  function automatic adl_pkg::q_t rand_small(int b);
    int v;
    v = int'($urandom_range(0, (2 << b) - 1)) - (1 << b);
    return adl_pkg::q_t'(v);
  endfunction

  function automatic logic rand_bit();
    return 1'($urandom_range(0, 1));
  endfunction

  // one request, with an optional random gap in front
  task automatic send_request(adl_pkg::in_payload_t req);
    int gap;
    gap = ($urandom_range(0, 99) < send_idle_pct) ? $urandom_range(1, 20) : 0;
    @(negedge clk);
    while (gap > 0) begin
      train_in_bus.valid <= 1'b0;
      gap--;
      @(negedge clk);
    end
    train_in_bus.valid   <= 1'b1;
    train_in_bus.payload <= req;
    do @(posedge clk); while (!train_in_bus.ready);
    items_sent++;
  endtask

  // drain every outstanding result, then let the pipeline settle
  task automatic wait_idle();
    @(negedge clk);
    train_in_bus.valid <= 1'b0;
    while (sb.expected_results.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_reg(logic [adl_pkg::CFG_IDX_W-1:0] index,
                           logic [adl_pkg::CFG_DATA_W-1:0] data);
    wait_idle();
    cfg_wr_en <= 1'b1;
    cfg_index <= index;
    cfg_data  <= data;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
    settings_written++;
  endtask

  task automatic configure(logic [adl_pkg::CFG_DATA_W-1:0] eta,
                           logic [adl_pkg::CFG_DATA_W-1:0] tol,
                           logic [adl_pkg::CFG_DATA_W-1:0] epochs);
    write_reg(adl_pkg::REG_LEARNING_RATE, eta);
    write_reg(adl_pkg::REG_ERROR_TOL, tol);
    write_reg(adl_pkg::REG_MAX_EPOCHS, epochs);
  endtask

  // field extremes, saturation, rounding and the epoch corner cases
  task automatic directed_checks();
    adl_pkg::q_t hi;
    adl_pkg::q_t lo;
    adl_pkg::q_t one;
    adl_pkg::q_t half;
    logic        trn;
    logic        lod;
    hi   = adl_pkg::Q_MAX;
    lo   = adl_pkg::Q_MIN;
    one  = adl_pkg::q_t'(1 << 20);
    half = adl_pkg::q_t'(1 << 19);
    trn  = adl_pkg::MODE_TRAIN;
    lod  = adl_pkg::MODE_LOAD;
    // zero weights against full scale inputs
    send_request(make_req(trn, hi, hi, hi, hi, hi, hi, 1'b0));
    send_request(make_req(trn, hi, hi, hi, hi, hi, lo, 1'b1));
    send_request(make_req(trn, lo, lo, lo, lo, lo, hi, 1'b0));
    send_request(make_req(trn, lo, hi, lo, hi, lo, lo, 1'b1));
    // load ignores target and end flag
    send_request(make_req(lod, hi, lo, 0, 1, -1, hi, 1'b1));
    send_request(make_req(trn, 1, -1, hi, lo, 0, 0, 1'b0));
    send_request(make_req(trn, lo, lo, lo, lo, lo, 0, 1'b1));
    // zero error converges at once, then tolerance edges
    send_request(make_req(lod, 0, 0, 0, 0, 0, 0, 1'b0));
    send_request(make_req(trn, 0, 0, 0, 0, 0, 0, 1'b1));
    send_request(make_req(trn, 0, 0, 0, 0, 0, 106, 1'b1));
    send_request(make_req(trn, 0, 0, 0, 0, 0, -105, 1'b1));
    // floor rounding of negative products
    send_request(make_req(lod, 3, -3, one, -one, 5, 0, 1'b0));
    send_request(make_req(trn, -1, -1, -1, -1, -1, 1, 1'b0));
    send_request(make_req(trn, half, -half, 7, -7, 1, -one, 1'b1));
    // epoch limit of zero stops at every epoch end
    write_reg(adl_pkg::REG_MAX_EPOCHS, '0);
    send_request(make_req(trn, rand_small(19), rand_small(19), rand_small(19),
                          rand_small(19), rand_small(19), hi, 1'b1));
    // epoch limit of one
    write_reg(adl_pkg::REG_MAX_EPOCHS, 1);
    send_request(make_req(lod, 0, 0, 0, 0, 0, 0, 1'b0));
    send_request(make_req(trn, rand_small(19), rand_small(19), rand_small(19),
                          rand_small(19), rand_small(19), lo, 1'b0));
    send_request(make_req(trn, rand_small(19), rand_small(19), rand_small(19),
                          rand_small(19), rand_small(19), hi, 1'b1));
    write_reg(adl_pkg::REG_MAX_EPOCHS, adl_pkg::CFG_DATA_W'(adl_pkg::EPOCHS_RESET));
  endtask

  // load, then several epochs over a fixed pattern set with a linear teacher
  task automatic train_sequence();
    adl_pkg::q_t teacher [adl_pkg::WEIGHT_COUNT];
    adl_pkg::q_t pattern [6][adl_pkg::WEIGHT_COUNT];
    int          patterns;
    int          epochs;
    int          bits;
    longint      acc;
    patterns = $urandom_range(2, 6);
    epochs   = $urandom_range(2, 5);
    bits     = ($urandom_range(0, 7) == 0) ? 22 : 19;
    foreach (teacher[i]) teacher[i] = rand_small(20);
    for (int p = 0; p < patterns; p++)
      for (int i = 0; i < adl_pkg::WEIGHT_COUNT; i++) pattern[p][i] = rand_small(bits);
    send_request(make_req(adl_pkg::MODE_LOAD, rand_small(20), rand_small(20), rand_small(20),
                          rand_small(20), rand_small(20), rand_q(), rand_bit()));
    for (int e = 0; e < epochs; e++) begin
      for (int p = 0; p < patterns; p++) begin
        acc = 0;
        for (int i = 0; i < adl_pkg::WEIGHT_COUNT; i++)
          acc += longint'(teacher[i]) * longint'(pattern[p][i]);
        send_request(make_req(adl_pkg::MODE_TRAIN, pattern[p][0], pattern[p][1],
                              pattern[p][2], pattern[p][3], pattern[p][4],
                              adl_pkg::q_t'(acc >>> adl_pkg::FRAC), p == patterns - 1));
      end
    end
  endtask

  // epoch cut short by a reload
  task automatic broken_sequence();
    int n;
    n = $urandom_range(1, 3);
    repeat (n)
      send_request(make_req(adl_pkg::MODE_TRAIN, rand_small(19), rand_small(19),
                            rand_small(19), rand_small(19), rand_small(19), rand_q(), 1'b0));
    send_request(make_req(adl_pkg::MODE_LOAD, rand_small(20), rand_small(20), rand_small(20),
                          rand_small(20), rand_small(20), rand_q(), 1'b0));
  endtask

  task automatic mixed_traffic(int count);
    int start;
    int pick;
    start = items_sent;
    while (items_sent - start < count) begin
      pick = $urandom_range(0, 9);
      if (pick < 7) begin
        train_sequence();
      end else if (pick == 7) begin
        send_request(make_req(adl_pkg::MODE_TRAIN, rand_q(), rand_q(), rand_q(), rand_q(),
                              rand_q(), rand_q(), rand_bit()));
      end else if (pick == 8) begin
        send_request(make_req(adl_pkg::MODE_LOAD, rand_q(), rand_q(), rand_q(), rand_q(),
                              rand_q(), rand_q(), rand_bit()));
      end else begin
        broken_sequence();
      end
    end
  endtask

  // long same-sign epochs drive the error sum into saturation
  task automatic sum_overflow_run();
    adl_pkg::q_t tgt;
    for (int dir = 0; dir < 2; dir++) begin
      send_request(make_req(adl_pkg::MODE_LOAD, 0, 0, 0, 0, 0, rand_q(), 1'b0));
      for (int k = 0; k < 261; k++) begin
        tgt = (dir == 0) ? adl_pkg::Q_MAX - adl_pkg::q_t'($urandom_range(0, 1000))
                         : adl_pkg::Q_MIN + adl_pkg::q_t'($urandom_range(0, 1000));
        send_request(make_req(adl_pkg::MODE_TRAIN, rand_q(), rand_q(), rand_q(), rand_q(),
                              rand_q(), tgt, k == 260));
      end
    end
  endtask

  // one-pattern epochs past the epoch counter ceiling
  task automatic epoch_limit_run(int count);
    send_request(make_req(adl_pkg::MODE_LOAD, rand_small(18), rand_small(18), rand_small(18),
                          rand_small(18), rand_small(18), 0, 1'b0));
    repeat (count)
      send_request(make_req(adl_pkg::MODE_TRAIN, rand_small(18), rand_small(18),
                            rand_small(18), rand_small(18), rand_small(18),
                            rand_small(20), 1'b1));
  endtask

  initial begin
    train_in_bus.valid   = 1'b0;
    train_in_bus.payload = '0;
    train_out_bus.ready  = 1'b0;
    cfg_wr_en            = 1'b0;
    cfg_index            = '0;
    cfg_data             = '0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    directed_checks();

    for (int ph = 0; ph < 8; ph++) begin
      wait_idle();
      // idle pattern of this phase
      case (ph % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 71; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 71; end
        default: begin send_idle_pct = 23; recv_stall_pct = 23; end
      endcase
      case (ph)
        0: begin
          configure({adl_pkg::ETA_W{1'b1}}, {adl_pkg::TOL_W{1'b1}}, 255);
          mixed_traffic(150);
        end
        1: begin
          configure(0, 0, 255);
          sum_overflow_run();
        end
        2: begin
          configure(adl_pkg::CFG_DATA_W'(1 << 16), adl_pkg::CFG_DATA_W'(1 << 14), 255);
          mixed_traffic(200);
        end
        3: begin
          configure(adl_pkg::CFG_DATA_W'($urandom_range(1 << 14, 1 << 20)),
                    adl_pkg::CFG_DATA_W'($urandom_range(0, 1 << 16)), 255);
          epoch_limit_run(270);
        end
        4: begin
          configure(adl_pkg::CFG_DATA_W'($urandom_range(0, 1 << 20)),
                    adl_pkg::CFG_DATA_W'($urandom_range(0, 1 << 12)), 1);
          mixed_traffic(150);
        end
        default: begin
          configure(adl_pkg::CFG_DATA_W'($urandom_range(0, 1 << 21)),
                    adl_pkg::CFG_DATA_W'($urandom_range(0, 1 << 16)),
                    adl_pkg::CFG_DATA_W'($urandom_range(1, 255)));
          mixed_traffic(150);
        end
      endcase
    end

    wait_idle();
    $display("covered %0d requests: %0d loads, %0d trains, %0d epoch ends, %0d stops",
             items_sent, sb.loads, sb.trains, sb.epoch_ends, sb.stops);
    $display("%0d results checked over %0d register writes, %0d mismatches",
             sb.checked, settings_written, sb.mismatches);
    if (sb.mismatches == 0) begin
      $display("PASS adaline_lms_trainer");
    end else begin
      $display("FAIL adaline_lms_trainer");
    end
    $finish;
  end
endmodule
